[rtl/core/pbe_pkg.sv]
// Package: Piccolo constants, S-box, F function and round key selection.
package pbe_pkg;

    localparam int NumStages = 32;               // whitening stage plus up to 31 rounds
    localparam int Rounds80 = 25;
    localparam int Rounds128 = 31;
    localparam logic [31:0] Con80Base = 32'h0F1E2D3C;
    localparam logic [31:0] Con128Base = 32'h6547A98B;
    localparam logic [4:0] GfPoly = 5'h13;

    localparam logic [1:0] RegKeyUpper = 2'd0;
    localparam logic [1:0] RegKeyLower = 2'd1;
    localparam logic [1:0] RegKeyMode = 2'd2;

    typedef logic [15:0] t_word;

    typedef struct packed {
        t_word x0;
        t_word x1;
        t_word x2;
        t_word x3;
    } t_state;

    function automatic logic [3:0] sbox(input logic [3:0] a);
        logic [3:0] r;
        unique case (a)
            4'h0: r = 4'hE;  4'h1: r = 4'h4;  4'h2: r = 4'hB;  4'h3: r = 4'h2;
            4'h4: r = 4'h3;  4'h5: r = 4'h8;  4'h6: r = 4'h0;  4'h7: r = 4'h9;
            4'h8: r = 4'h1;  4'h9: r = 4'hA;  4'hA: r = 4'h7;  4'hB: r = 4'hF;
            4'hC: r = 4'h6;  4'hD: r = 4'hC;  4'hE: r = 4'h5;  default: r = 4'hD;
        endcase
        return r;
    endfunction

    // Multiply by x in GF(16) modulo x^4+x+1.
    function automatic logic [3:0] xtime(input logic [3:0] a);
        return a[3] ? ({a[2:0], 1'b0} ^ GfPoly[3:0]) : {a[2:0], 1'b0};
    endfunction

    function automatic t_word f_func(input t_word x);
        logic [3:0] n0, n1, n2, n3;
        logic [3:0] y0, y1, y2, y3;
        n0 = sbox(x[15:12]);
        n1 = sbox(x[11:8]);
        n2 = sbox(x[7:4]);
        n3 = sbox(x[3:0]);
        y0 = xtime(n0) ^ xtime(n1) ^ n1 ^ n2 ^ n3;
        y1 = n0 ^ xtime(n1) ^ xtime(n2) ^ n2 ^ n3;
        y2 = n0 ^ n1 ^ xtime(n2) ^ xtime(n3) ^ n3;
        y3 = xtime(n0) ^ n0 ^ n1 ^ n2 ^ xtime(n3);
        return {sbox(y0), sbox(y1), sbox(y2), sbox(y3)};
    endfunction

    function automatic logic [31:0] round_con(input logic [4:0] j, input logic [31:0] base);
        logic [31:0] c;
        c = {27'd0, j};
        return (c << 27) ^ (c << 17) ^ (c << 10) ^ c ^ base;
    endfunction

    // Key word index used by round-key word i of the 128-bit schedule.
    // The permutation applied every fourth round is folded in at elaboration.
    function automatic logic [2:0] k128_index(input int unsigned i);
        int unsigned perm [8];
        int unsigned t [8];
        int unsigned c;
        int unsigned m;
        int unsigned j;
        int unsigned res;
        for (m = 0; m < 8; m++) perm[m] = m;
        res = 0;
        for (j = 0; j <= i; j++) begin
            c = (j + 2) % 8;
            if (c == 0) begin
                t[0] = perm[2]; t[1] = perm[1]; t[2] = perm[6]; t[3] = perm[7];
                t[4] = perm[0]; t[5] = perm[3]; t[6] = perm[4]; t[7] = perm[5];
                for (m = 0; m < 8; m++) perm[m] = t[m];
            end
            res = perm[c];
        end
        return res[2:0];
    endfunction

    // Round keys for round r (0-based) in either mode.
    function automatic logic [31:0] round_key(input int unsigned r, input logic mode,
                                              input logic [127:0] key);
        t_word k [8];
        logic [31:0] con;
        t_word a;
        t_word b;
        int unsigned m;
        for (m = 0; m < 8; m++) k[m] = key[127 - 16*m -: 16];
        if (!mode) begin
            con = round_con(5'(r + 1), Con80Base);
            unique case (r % 5)
                0, 2: begin a = k[2]; b = k[3]; end
                1, 4: begin a = k[0]; b = k[1]; end
                default: begin a = k[4]; b = k[4]; end
            endcase
        end else begin
            con = round_con(5'(r + 1), Con128Base);
            a = k[k128_index(2*r)];
            b = k[k128_index(2*r + 1)];
        end
        return {con[31:16] ^ a, con[15:0] ^ b};
    endfunction

endpackage

[rtl/core/pbe_round.sv]
// One pipeline stage: Piccolo round with permutation or output whitening, or bypass.
module pbe_round (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic            i_active,
    input  logic            i_last,
    input  logic [31:0]     i_rk,
    input  logic [31:0]     i_wk_out,
    input  pbe_pkg::t_state i_state,
    output logic            o_valid,
    output pbe_pkg::t_state o_state
);
    import pbe_pkg::*;

    logic   r_valid;
    t_state r_state;
    t_state n_state;
    t_word  y1;
    t_word  y3;

    always_comb begin
        y1 = i_state.x1 ^ f_func(i_state.x0) ^ i_rk[31:16];
        y3 = i_state.x3 ^ f_func(i_state.x2) ^ i_rk[15:0];
        if (!i_active) begin
            n_state = i_state;
        end else if (i_last) begin
            n_state = '{i_state.x0 ^ i_wk_out[31:16], y1,
                        i_state.x2 ^ i_wk_out[15:0], y3};
        end else begin
            n_state = '{{y1[15:8], y3[7:0]}, {i_state.x2[15:8], i_state.x0[7:0]},
                        {y3[15:8], y1[7:0]}, {i_state.x0[15:8], i_state.x2[7:0]}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_state <= n_state;
        end
    end

    assign o_valid = r_valid;
    assign o_state = r_state;

endmodule

[rtl/core/piccolo_block_encrypt_top.sv]
// Top level: Piccolo-64 encryption pipeline with an APB key port.
// Path: input whitening register, one register stage per round, then the output register.
// Throughput: one block per cycle while the output register is free or taken; the whole
// pipeline advances together and stalls as one under back-pressure.
// In 80-bit mode the last six stages pass the block through unchanged.
// Reset (synchronous, active low) clears all valid bits and the key registers.
module piccolo_block_encrypt_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [63:0] plaintext
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata    // [63:0] ciphertext
);
    import pbe_pkg::*;

    logic [63:0] r_key_upper;
    logic [63:0] r_key_lower;
    logic        r_key_mode;
    logic [1:0]  reg_idx;
    logic        cfg_wr;
    logic        adv;
    logic [127:0] key;
    t_word        k [8];
    t_word        wk0, wk1, wk2, wk3;

    t_state st [NumStages + 1];
    logic   vl [NumStages + 1];
    logic   r_in_valid;
    t_state r_in_state;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:3];
    assign cfg_wr  = psel && penable && pwrite && pready;

    // Registers sit at 8*i: paddr[4:3] picks the register, index 3 is unused.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_upper <= '0;
            r_key_lower <= '0;
            r_key_mode  <= 1'b0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                RegKeyUpper: r_key_upper <= pwdata;
                RegKeyLower: r_key_lower <= pwdata;
                RegKeyMode:  r_key_mode  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            RegKeyUpper: prdata = r_key_upper;
            RegKeyLower: prdata = r_key_lower;
            RegKeyMode:  prdata = {63'd0, r_key_mode};
            default:     prdata = '0;
        endcase
    end

    assign key = {r_key_upper, r_key_lower};
    always_comb begin
        for (int m = 0; m < 8; m++) k[m] = key[127 - 16*m -: 16];
    end
    assign wk0 = {k[0][15:8], k[1][7:0]};
    assign wk1 = {k[1][15:8], k[0][7:0]};
    assign wk2 = r_key_mode ? {k[4][15:8], k[7][7:0]} : {k[4][15:8], k[3][7:0]};
    assign wk3 = r_key_mode ? {k[7][15:8], k[4][7:0]} : {k[3][15:8], k[4][7:0]};

    // Advance the whole pipeline when the output register is empty or being taken.
    assign adv = !vl[NumStages] || m_axis_tready;
    assign s_axis_tready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (adv) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_in_state <= '{s_axis_tdata[63:48] ^ wk0, s_axis_tdata[47:32],
                            s_axis_tdata[31:16] ^ wk1, s_axis_tdata[15:0]};
        end
    end

    assign vl[0] = r_in_valid;
    assign st[0] = r_in_state;

    for (genvar g = 0; g < NumStages - 1; g++) begin : g_round
        logic        active;
        logic        last;
        logic [31:0] rk;
        assign active = r_key_mode ? (g < Rounds128) : (g < Rounds80);
        assign last   = r_key_mode ? (g == Rounds128 - 1) : (g == Rounds80 - 1);
        assign rk     = round_key(g, r_key_mode, key);
        pbe_round u_round (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (adv),
            .i_valid  (vl[g]),
            .i_active (active),
            .i_last   (last),
            .i_rk     (rk),
            .i_wk_out ({wk2, wk3}),
            .i_state  (st[g]),
            .o_valid  (vl[g + 1]),
            .o_state  (st[g + 1])
        );
    end

    // output register
    logic   r_out_valid;
    t_state r_out_state;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= vl[NumStages - 1];
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_state <= st[NumStages - 1];
        end
    end
    assign vl[NumStages] = r_out_valid;
    assign st[NumStages] = r_out_state;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_state;

    // Stalled output holds its data.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed under stall");
    // Pipeline only frozen by a stalled output.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("pipeline stalled without back-pressure");
    // An accepted item reaches the input whitening register.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> vl[0])
        else $error("accepted item lost");

endmodule
